/* hdl/rspf_pkg.sv */
// Shared types, constants and tables for the range scan point fusion block.
package rspf_pkg;

  localparam int MAX_RAYS     = 1024;
  localparam int RAY_W        = $clog2(MAX_RAYS);
  localparam int CNT_W        = RAY_W + 1;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int ITER_W       = 5;
  // CORDIC datapath width: coordinates scaled by 256 plus growth headroom.
  localparam int CW           = 28;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_RAY_COUNT   = 3'd2,
    REG_MIN_RANGE   = 3'd3,
    REG_MAX_RANGE   = 3'd4,
    REG_WINDOW      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]     start_angle;
    logic [15:0]     angle_step;
    logic [CNT_W-1:0] ray_count;
    logic [15:0]     min_range;
    logic [15:0]     max_range;
    logic [3:0]      half_width;
  } cfg_t;

  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/rspf_cordic.sv */
// Iterative CORDIC vectoring unit that returns a point's bearing in binary angle.
module rspf_cordic import rspf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic signed [15:0]    px,
  input  logic signed [15:0]    py,
  output logic                  done,
  output logic [ANGLE_BITS-1:0] bearing
);

  logic signed [CW-1:0] x, y;
  logic [31:0]          acc;
  logic [ITER_W-1:0]    iter;
  logic                 active;
  logic signed [CW-1:0] dx, dy, sx, sy;
  logic [31:0]          rounded;

  // Arithmetic right shift is a floor shift on two's complement values.
  assign dx = y >>> iter;
  assign dy = x >>> iter;
  assign sx = CW'(px) <<< 8;
  assign sy = CW'(py) <<< 8;
  assign rounded = acc + (32'd1 << (31 - ANGLE_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        iter <= '0;
        if (px == 16'sd0 && py == 16'sd0) begin
          active <= 1'b1;
          x   <= '0;
          y   <= '0;
          acc <= '0;
        end else begin
          active <= 1'b1;
          if (px < 0) begin
            x   <= -sx;
            y   <= -sy;
            acc <= 32'h8000_0000;
          end else begin
            x   <= sx;
            y   <= sy;
            acc <= '0;
          end
        end
      end else if (active) begin
        if (y == 0 || iter == ITER_W'(CORDIC_STEPS)) begin
          active  <= 1'b0;
          done    <= 1'b1;
          bearing <= rounded[31 -: ANGLE_BITS];
        end else begin
          if (y > 0) begin
            x   <= x + dx;
            y   <= y - dy;
            acc <= acc + atan_turn(iter);
          end else begin
            x   <= x - dx;
            y   <= y + dy;
            acc <= acc - atan_turn(iter);
          end
          iter <= iter + 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/rspf_arith.sv */
// Squared distance, rounded square root and bearing-to-ray division.
module rspf_arith import rspf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic signed [15:0]    px,
  input  logic signed [15:0]    py,
  input  logic                  div_go,
  input  logic [ANGLE_BITS-1:0] rel,
  input  logic [15:0]           step,
  output logic                  done,
  output logic [31:0]           d2,
  output logic [15:0]           dist_mm,
  output logic                  div_done,
  output logic [ANGLE_BITS-1:0] quot
);

  // Square root: one result bit per cycle, restoring method.
  logic [31:0] rem, rt;
  logic [31:0] bitv;
  logic [1:0]  phase;
  logic [31:0] xx, yy;
  logic [31:0] trial;
  logic [16:0] r17;

  assign trial = rt + bitv;
  assign r17   = (rem > rt) ? 17'(rt) + 17'd1 : 17'(rt);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        xx    <= 32'($signed(px) * $signed(px));
        yy    <= 32'($signed(py) * $signed(py));
        phase <= 2'd1;
      end else if (phase == 2'd1) begin
        d2    <= xx + yy;
        rem   <= xx + yy;
        rt    <= '0;
        bitv  <= 32'h4000_0000;
        phase <= 2'd2;
      end else if (phase == 2'd2) begin
        if (bitv == 0) begin
          phase   <= 2'd0;
          done    <= 1'b1;
          dist_mm <= r17[16] ? 16'hFFFF : r17[15:0];
        end else begin
          if (rem >= trial) begin
            rem <= rem - trial;
            rt  <= (rt >> 1) + bitv;
          end else begin
            rt <= rt >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
    end
  end

  // Division: one quotient bit per cycle.
  logic [ANGLE_BITS-1:0] dq;
  logic [16:0]           dr;
  logic [4:0]            dcnt;
  logic                  dact;
  logic [16:0]           dsh;

  assign dsh = {dr[15:0], dq[ANGLE_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dact     <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (div_go) begin
        dq   <= rel;
        dr   <= '0;
        dcnt <= 5'(ANGLE_BITS);
        dact <= 1'b1;
      end else if (dact) begin
        if (dsh >= {1'b0, step}) begin
          dr <= dsh - {1'b0, step};
          dq <= {dq[ANGLE_BITS-2:0], 1'b1};
        end else begin
          dr <= dsh;
          dq <= {dq[ANGLE_BITS-2:0], 1'b0};
        end
        dcnt <= dcnt - 1'b1;
        if (dcnt == 5'd1) begin
          dact     <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  assign quot = dq;

endmodule

/* hdl/rspf_ctrl.sv */
// Command sequencer owning the ray range memory.
module rspf_ctrl import rspf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cfg_t             cfg,
  input  logic [1:0]       command,
  input  logic [RAY_W-1:0] ray_slot,
  input  logic [15:0]      range_in,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  output logic             done,
  output logic [15:0]      range_out,
  output logic [RAY_W-1:0] hit_ray,
  output logic             replaced,
  output logic             outside_scan
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_MATH  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_TEST  = 7'b0100000,
    S_FILL  = 7'b1000000
  } state_t;

  state_t state;
  logic [15:0] mem [MAX_RAYS];
  logic [15:0] rd_data;
  logic [RAY_W-1:0] rd_addr, wr_addr;
  logic        wr_en;
  logic [15:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic cordic_go, cordic_done, math_done, div_go, div_done;
  logic [ANGLE_BITS-1:0] bearing, quot, rel;
  logic [31:0] d2;
  logic [15:0] dist_mm, step;
  logic have_bear, have_math;
  logic [RAY_W-1:0] ray, hi, cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W+3:0] up;

  // Both units capture the point at the accepting edge.
  rspf_cordic u_cordic (.clk, .rst, .go(cordic_go), .px(point_x), .py(point_y),
                        .done(cordic_done), .bearing);
  rspf_arith u_arith (.clk, .rst, .go(cordic_go), .px(point_x), .py(point_y),
                      .div_go, .rel, .step, .done(math_done), .d2, .dist_mm,
                      .div_done, .quot);

  assign busy  = (state != S_IDLE);
  assign step  = (cfg.angle_step == 16'd0) ? 16'd1 : cfg.angle_step;
  assign count = (cfg.ray_count > CNT_W'(MAX_RAYS)) ? CNT_W'(MAX_RAYS) : cfg.ray_count;
  assign rel   = bearing - cfg.start_angle[ANGLE_BITS-1:0];
  assign cordic_go = start && !busy && command == CMD_MERGE;
  assign div_go = (state == S_MATH) && have_bear && have_math;
  assign rd_addr = (state == S_IDLE) ? ray_slot : ray;
  assign up = (CNT_W+4)'(ray) + (CNT_W+4)'(cfg.half_width);

  logic [31:0] cur_sq;
  logic        keep;
  assign cur_sq = 32'(rd_data) * 32'(rd_data);
  assign keep = rd_data > cfg.min_range && rd_data < cfg.max_range && cur_sq < d2;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ray_slot;
    wr_data = range_in;
    if (start && !busy && command == CMD_LOAD) wr_en = 1'b1;
    if (state == S_FILL) begin
      wr_en   = 1'b1;
      wr_addr = cur;
      wr_data = dist_mm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            range_out <= '0; hit_ray <= '0; replaced <= 1'b0; outside_scan <= 1'b0;
            case (command)
              CMD_LOAD: begin range_out <= range_in; done <= 1'b1; end
              CMD_READ: state <= S_READ;
              CMD_MERGE: begin
                have_bear <= 1'b0; have_math <= 1'b0; state <= S_MATH;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          range_out <= rd_data; done <= 1'b1; state <= S_IDLE;
        end
        S_MATH: begin
          if (cordic_done) have_bear <= 1'b1;
          if (math_done) have_math <= 1'b1;
          if (div_go) state <= S_DIV;
        end
        S_DIV: if (div_done) begin
          if ({{(ANGLE_BITS-CNT_W){1'b0}}, count} <= quot) begin
            outside_scan <= 1'b1; done <= 1'b1; state <= S_IDLE;
          end else begin
            ray <= RAY_W'(quot); state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_TEST;
        S_TEST: begin
          range_out <= dist_mm; hit_ray <= ray;
          if (keep) begin
            done <= 1'b1; state <= S_IDLE;
          end else begin
            replaced <= 1'b1;
            cur <= (ray > RAY_W'(cfg.half_width)) ? ray - RAY_W'(cfg.half_width) : '0;
            hi  <= (up >= (CNT_W+4)'(count)) ? RAY_W'(count - 1'b1) : RAY_W'(up);
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (cur == hi) begin
            done <= 1'b1; state <= S_IDLE;
          end
          cur <= cur + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/range_scan_point_fusion.sv */
// Top level of the range scan point fusion block.
// A command is taken when start is high and busy is low; one result follows,
// shown for one cycle with done. Load and unknown commands answer from idle,
// read after a registered memory read. Merge finds the bearing (up to 28
// CORDIC iterations, the bit-serial square root running alongside), then
// the ray by division, and ends there if it is outside the scan; else it
// tests that ray and, to replace it, writes one window ray per cycle, up to
// 31 rays. Results cannot be stalled. Ray memory is undefined until written.
module range_scan_point_fusion import rspf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [RAY_W-1:0]   ray_slot,
  input  logic [15:0]        range_in,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  output logic               done,
  output logic [15:0]        range_out,
  output logic [RAY_W-1:0]   hit_ray,
  output logic               replaced,
  output logic               outside_scan,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_angle <= 16'h8000;
      cfg.angle_step  <= 16'd64;
      cfg.ray_count   <= CNT_W'(1024);
      cfg.min_range   <= 16'd100;
      cfg.max_range   <= 16'd30000;
      cfg.half_width  <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ANGLE: cfg.start_angle <= cfg_data;
        REG_ANGLE_STEP:  cfg.angle_step  <= cfg_data;
        REG_RAY_COUNT:   cfg.ray_count   <= cfg_data[CNT_W-1:0];
        REG_MIN_RANGE:   cfg.min_range   <= cfg_data;
        REG_MAX_RANGE:   cfg.max_range   <= cfg_data;
        REG_WINDOW:      cfg.half_width  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  rspf_ctrl u_ctrl (.clk, .rst, .start, .busy, .cfg, .command, .ray_slot,
                    .range_in, .point_x, .point_y, .done, .range_out, .hit_ray,
                    .replaced, .outside_scan);

endmodule

/* hdl/rspf_checker.sv */
// Port-level checks for the range scan point fusion block.
module rspf_checker import rspf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [15:0]      range_out,
  input logic [RAY_W-1:0] hit_ray,
  input logic             replaced,
  input logic             outside_scan
);

  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(replaced && outside_scan)) else $error("replaced with outside");
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    done && outside_scan |-> range_out == 16'd0 && hit_ray == '0)
    else $error("outside result not zero");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done || !$past(busy)) else $error("double done");
  // A command transfer either occupies the block or finishes at once.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("command lost");

endmodule

bind range_scan_point_fusion rspf_checker u_chk (.clk, .rst, .start, .busy, .done,
  .range_out, .hit_ray, .replaced, .outside_scan);

/* tb/tb_range_scan_point_fusion.sv */
// Testbench for range_scan_point_fusion: queued commands checked against a local predictor.
`timescale 1ns / 100ps
module tb_range_scan_point_fusion;
  import rspf_pkg::*;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  slot;
    logic [15:0] rng;
    logic [15:0] px;
    logic [15:0] py;
  } scan_cmd_t;

  typedef struct {
    logic [15:0] range_v;
    logic [9:0]  hit;
    logic        repl;
    logic        outside;
  } fusion_res_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int QUIET_CYCLES   = 120;

  localparam logic [31:0] ARCTAN_TURN [28] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5};

  logic clk, rst, start, busy, done, replaced, outside_scan;
  logic cfg_valid, cfg_ready;
  logic [1:0]  command;
  logic [9:0]  ray_slot, hit_ray;
  logic [15:0] range_in, range_out, cfg_data;
  logic signed [15:0] point_x, point_y;
  logic [2:0]  cfg_index;

  range_scan_point_fusion u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .ray_slot(ray_slot), .range_in(range_in), .point_x(point_x), .point_y(point_y),
    .done(done), .range_out(range_out), .hit_ray(hit_ray), .replaced(replaced),
    .outside_scan(outside_scan), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [15:0] ray_mem [1024];
  logic [15:0] start_angle_r, angle_step_r, min_range_r, max_range_r;
  logic [10:0] ray_count_r;
  logic [3:0]  half_width_r;

  scan_cmd_t   pending_cmds[$];
  fusion_res_t expected_results[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  bit          taken = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [15:0] point_bearing(longint px, longint py);
    longint x, y, dx, dy;
    logic [31:0] acc;
    acc = 0;
    x = px * 256;
    y = py * 256;
    if (px == 0 && py == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    for (int i = 0; i < 28 && y != 0; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        acc += ARCTAN_TURN[i];
      end else begin
        x -= dx;
        y += dy;
        acc -= ARCTAN_TURN[i];
      end
    end
    acc += 32'h0000_8000;
    return acc[31:16];
  endfunction

  function automatic longint rounded_root(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  function automatic fusion_res_t fuse_command(scan_cmd_t c);
    fusion_res_t res;
    longint px, py, d2, dist_mm, cur;
    int count, step, ray, lo, hi, w;
    logic [15:0] rel;
    res = '{16'd0, 10'd0, 1'b0, 1'b0};
    case (c.cmd)
      CMD_LOAD: begin
        ray_mem[c.slot] = c.rng;
        res.range_v = c.rng;
      end
      CMD_READ: res.range_v = ray_mem[c.slot];
      CMD_MERGE: begin
        px = longint'($signed(c.px));
        py = longint'($signed(c.py));
        count = ray_count_r > 1024 ? 1024 : ray_count_r;
        step = angle_step_r == 0 ? 1 : angle_step_r;
        rel = point_bearing(px, py) - start_angle_r;
        ray = rel / step;
        if (ray >= count) begin
          res.outside = 1'b1;
        end else begin
          d2 = px * px + py * py;
          dist_mm = rounded_root(d2);
          if (dist_mm > 65535) dist_mm = 65535;
          cur = ray_mem[ray];
          res.hit = ray[9:0];
          res.range_v = dist_mm[15:0];
          if (!(cur > min_range_r && cur < max_range_r && cur * cur < d2)) begin
            w = half_width_r;
            lo = ray > w ? ray - w : 0;
            hi = ray + w >= count ? count - 1 : ray + w;
            for (int i = lo; i <= hi; i++) ray_mem[i] = dist_mm[15:0];
            res.repl = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Monitor: checks results, then records the transfer of a new command.
  always @(posedge clk) begin
    fusion_res_t want;
    scan_cmd_t c;
    if (!rst) begin
      idle_cycles++;
      if (done) begin
        idle_cycles = 0;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", range_out, 0);
        end else begin
          want = expected_results.pop_front();
          if (range_out !== want.range_v) report_mismatch("range_out", range_out, want.range_v);
          if (hit_ray !== want.hit) report_mismatch("hit_ray", hit_ray, want.hit);
          if (replaced !== want.repl) report_mismatch("replaced", replaced, want.repl);
          if (outside_scan !== want.outside)
            report_mismatch("outside_scan", outside_scan, want.outside);
        end
      end
      if (start && !busy) begin
        idle_cycles = 0;
        c.cmd = cmd_t'(command);
        c.slot = ray_slot;
        c.rng = range_in;
        c.px = point_x;
        c.py = point_y;
        expected_results = {expected_results, fuse_command(c)};
        taken = 1;
      end
      if (cfg_valid && cfg_ready) idle_cycles = 0;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Driver: presents queued commands with random gaps.
  always @(negedge clk) begin
    logic nxt;
    scan_cmd_t c;
    nxt = start;
    if (taken) begin
      taken = 0;
      nxt = 0;
      gap_left = pick_gap();
    end
    if (!rst && !nxt && pending_cmds.size() != 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        c = pending_cmds.pop_front();
        command <= c.cmd;
        ray_slot <= c.slot;
        range_in <= c.rng;
        point_x <= c.px;
        point_y <= c.py;
        nxt = 1;
      end
    end
    start <= nxt;
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_ANGLE: start_angle_r = value;
      REG_ANGLE_STEP:  angle_step_r = value;
      REG_RAY_COUNT:   ray_count_r = value[10:0];
      REG_MIN_RANGE:   min_range_r = value;
      REG_MAX_RANGE:   max_range_r = value;
      REG_WINDOW:      half_width_r = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_cmd(cmd_t cmd, int slot, int rng, int px, int py);
    scan_cmd_t c;
    c.cmd = cmd;
    c.slot = slot[9:0];
    c.rng = rng[15:0];
    c.px = px[15:0];
    c.py = py[15:0];
    pending_cmds = {pending_cmds, c};
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Points are mostly within sensor range so that both keep and overwrite happen.
  task automatic queue_random(int n);
    int p, lim;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      lim = ($urandom_range(0, 3) == 0) ? 32767 : 3000;
      if (p < 25)
        queue_cmd(CMD_LOAD, $urandom_range(0, 1023),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(50, 5000), 0, 0);
      else if (p < 75)
        queue_cmd(CMD_MERGE, $urandom_range(0, 1023), $urandom_range(0, 65535),
                  $signed($urandom_range(0, 2 * lim + 1)) - lim - 1,
                  $signed($urandom_range(0, 2 * lim + 1)) - lim - 1);
      else if (p < 95)
        queue_cmd(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
      else
        queue_cmd(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
    end
  endtask

  task automatic set_all(int sa, int st, int rc, int mn, int mx, int hw);
    write_reg(REG_START_ANGLE, sa[15:0]);
    write_reg(REG_ANGLE_STEP, st[15:0]);
    write_reg(REG_RAY_COUNT, rc[15:0]);
    write_reg(REG_MIN_RANGE, mn[15:0]);
    write_reg(REG_MAX_RANGE, mx[15:0]);
    write_reg(REG_WINDOW, hw[15:0]);
  endtask

  initial begin
    int tmo;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_LOAD;
    ray_slot = '0;
    range_in = '0;
    point_x = '0;
    point_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_START_ANGLE;
    cfg_data = '0;
    start_angle_r = 16'h8000;
    angle_step_r = 16'd64;
    ray_count_r = 11'd1024;
    min_range_r = 16'd100;
    max_range_r = 16'd30000;
    half_width_r = 4'd2;
    foreach (ray_mem[i]) ray_mem[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Every ray is written first so that no read ever sees an unwritten entry.
    for (int i = 0; i < 1024; i++) queue_cmd(CMD_LOAD, i, $urandom_range(0, 8000), 0, 0);
    queue_cmd(CMD_LOAD, 1023, 65535, 0, 0);
    queue_cmd(CMD_LOAD, 0, 0, 0, 0);
    queue_cmd(CMD_READ, 1023, 0, 0, 0);
    queue_cmd(CMD_READ, 0, 65535, -1, -1);
    queue_cmd(CMD_MERGE, 0, 0, 0, 0);
    queue_cmd(CMD_MERGE, 0, 0, 32767, 32767);
    queue_cmd(CMD_MERGE, 0, 0, -32768, -32768);
    queue_cmd(CMD_MERGE, 0, 0, -32768, 0);
    queue_cmd(CMD_MERGE, 0, 0, 0, -32768);
    queue_cmd(CMD_MERGE, 0, 0, 0, 32767);
    queue_cmd(CMD_MERGE, 0, 0, 1000, 0);
    queue_cmd(CMD_MERGE, 0, 0, 2000, 0);
    queue_cmd(CMD_MERGE, 0, 0, 500, 0);
    queue_cmd(CMD_MERGE, 0, 0, -1000, 1);
    queue_cmd(CMD_NONE, 1023, 65535, 32767, -32768);
    queue_cmd(CMD_READ, 512, 0, 0, 0);
    drain();

    set_all(-32768, 64, 1024, 100, 30000, 2);
    queue_random(80);
    drain();
    set_all(32767, 1, 1, 0, 65535, 15);
    queue_random(60);
    drain();
    set_all(0, 0, 0, 65535, 0, 0);
    queue_random(40);
    drain();
    set_all(-1, 65535, 2047, 50, 4000, 7);
    queue_random(60);
    drain();
    set_all(16384, 32, 1024, 200, 2500, 15);
    queue_random(100);
    drain();
    set_all($urandom_range(0, 65535), $urandom_range(16, 200), $urandom_range(100, 1100),
            $urandom_range(0, 300), $urandom_range(1000, 6000), $urandom_range(0, 15));
    queue_random(120);

    tmo = 0;
    while ((pending_cmds.size() != 0 || start || expected_results.size() != 0)
           && tmo < 200000) begin
      @(posedge clk);
      tmo++;
    end
    repeat (QUIET_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0 && tmo < 200000) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
